// ===== hdl/rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// rbf_pkg: shared types and constants of the radial brush falloff weight block
// Item formats, controller states, datapath commands and the constant tables
// used by the cosine series.
// ----------------------------------------------------------------------------
`default_nettype none

package rbf_pkg;

  localparam int CRD_W       = 24;
  localparam int RAD_W       = 23;
  localparam int IDX_W       = 20;
  localparam int DIST_W      = 24;
  localparam int WGT_W       = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int SQ_W        = 50;
  localparam int ROOT_W      = 25;
  localparam int REM_W       = 26;
  localparam int SQRT_STEPS  = 25;
  localparam int DIV_NW      = 45;
  localparam int DIV_DW      = 23;
  localparam int COS_STEPS   = 5;
  localparam int RCP_W       = 29;
  localparam int CDIV_W      = 8;
  localparam int MUL_W       = 32;

  localparam logic [WGT_W-1:0] WGT_ONE     = 17'h10000;
  localparam logic [30:0]      HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0]      Q30_ONE     = 32'h4000_0000;

  localparam logic [1:0] MODE_CONST  = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_SQUARE = 2'd2;
  localparam logic [1:0] MODE_COSINE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd3;

  typedef struct packed {
    logic signed [CRD_W-1:0] vertex_x;
    logic signed [CRD_W-1:0] vertex_y;
    logic signed [CRD_W-1:0] vertex_height;
    logic [IDX_W-1:0]        vertex_index;
    logic                    batch_last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_index;
    logic                    affected;
    logic [DIST_W-1:0]       distance;
    logic [WGT_W-1:0]        weight;
    logic                    out_last;
    logic signed [CRD_W-1:0] average_height;
    logic                    average_valid;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_R, S_SQ_X, S_SQ_Y, S_CMP, S_SQRT, S_WSEL, S_DIV_W, S_SQUARE,
    S_COS_X, S_COS_Y, S_COS_RCP, S_COS_FIX, S_COS_MUL, S_COS_HALF, S_COS_FMUL,
    S_COS_END, S_ACCUM, S_AVG_CHK, S_DIV_A, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQ_R, OP_SQ_X, OP_SQ_Y, OP_CMP, OP_SQRT, OP_WSEL,
    OP_TAKE_W, OP_SQUARE, OP_COS_X, OP_COS_Y, OP_COS_RCP, OP_COS_FIX,
    OP_COS_MUL, OP_COS_HALF, OP_COS_END, OP_ACCUM, OP_AVG_START, OP_TAKE_A,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] step;
  } cmd_t;

  typedef struct packed {
    logic       aff;
    logic       trivial;
    logic [1:0] mode;
    logic       last;
    logic       count_nz;
    logic       div_done;
  } sts_t;

  // Series divisors, innermost term first.
  function automatic logic [CDIV_W-1:0] cos_div(input logic [2:0] step);
    logic [CDIV_W-1:0] k;
    case (step)
      3'd0:    k = 8'd132;
      3'd1:    k = 8'd90;
      3'd2:    k = 8'd56;
      3'd3:    k = 8'd30;
      3'd4:    k = 8'd12;
      default: k = 8'd12;
    endcase
    return k;
  endfunction

  // floor(2^32 / divisor); the quotient it gives is low by at most one.
  function automatic logic [RCP_W-1:0] cos_recip(input logic [2:0] step);
    logic [RCP_W-1:0] m;
    case (step)
      3'd0:    m = 29'd32537631;
      3'd1:    m = 29'd47721858;
      3'd2:    m = 29'd76695844;
      3'd3:    m = 29'd143165576;
      3'd4:    m = 29'd357913941;
      default: m = 29'd357913941;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rbf_div.sv =====
// ----------------------------------------------------------------------------
// rbf_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses after the run.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_div
  import rbf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] dividend,
  input  wire logic [DIV_DW-1:0] divisor,
  output logic                   done,
  output logic [DIV_NW-1:0]      quotient
);

  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] dvs_r, dvs_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_DW:0]   rem_sh;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_NW-1]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_DW'(rem_sh - {1'b0, dvs_r});
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== hdl/rbf_dp.sv =====
// ----------------------------------------------------------------------------
// rbf_dp: datapath of the radial brush falloff weight block
// Configuration registers, distance, square root, weight series, batch sum
// and the result register, all stepped by commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_dp
  import rbf_pkg::*;
#(
  parameter int MAX_VERTICES = 1048576
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  input  wire in_item_t              in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output sts_t                       sts,
  output out_item_t                  out_data
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W = CRD_W + CNT_W;

  logic signed [CRD_W-1:0] cx_r, cy_r;
  logic [RAD_W-1:0]        rad_r;
  logic [1:0]              mode_r;

  logic [ROOT_W-1:0]       adx_r, ady_r, adx_nxt, ady_nxt;
  logic signed [CRD_W-1:0] hgt_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    last_r;
  logic [SQ_W-1:0]         acc_r, acc_nxt;
  logic [45:0]             rr_r, rr_nxt;
  logic                    aff_r, aff_nxt;
  logic [REM_W-1:0]        srem_r, srem_nxt;
  logic [ROOT_W-1:0]       root_r, root_nxt;
  logic [WGT_W-1:0]        w_r, w_nxt;
  logic [WGT_W-1:0]        t_r, t_nxt;
  logic [30:0]             x_r, x_nxt;
  logic [31:0]             y_r, y_nxt;
  logic [RCP_W-1:0]        qa_r, qa_nxt;
  logic [30:0]             q_r, q_nxt;
  logic [30:0]             p_r, p_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [CRD_W-1:0] avg_r, avg_nxt;
  logic                    avalid_r, avalid_nxt;
  out_item_t               out_r, out_nxt;

  logic [MUL_W-1:0]        mul_a, mul_b;
  logic [2*MUL_W-1:0]      mul_p;
  logic signed [CRD_W:0]   ddx, ddy;
  logic [REM_W+1:0]        rem_sh, trial;
  logic [RAD_W-1:0]        num;
  logic [36:0]             qk, crem;
  logic [31:0]             prod30;
  logic [31:0]             wsum;
  logic [SUM_W-1:0]        sum_mag;
  logic [CRD_W-1:0]        q24;
  logic                    div_start, div_done;
  logic [DIV_NW-1:0]       div_a, div_q;
  logic [DIV_DW-1:0]       div_b;
  logic [CDIV_W-1:0]       kdiv;
  logic                    trivial, count_full;

  assign trivial    = (rad_r == '0) || (mode_r == MODE_CONST);
  assign count_full = count_r >= CNT_W'(MAX_VERTICES);
  assign kdiv       = cos_div(cmd.step);

  // One shared multiplier, operands chosen by the current command.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQ_R: begin
        mul_a = MUL_W'(rad_r);
        mul_b = MUL_W'(rad_r);
      end
      OP_SQ_X: begin
        mul_a = MUL_W'(adx_r);
        mul_b = MUL_W'(adx_r);
      end
      OP_SQ_Y: begin
        mul_a = MUL_W'(ady_r);
        mul_b = MUL_W'(ady_r);
      end
      OP_SQUARE: begin
        mul_a = MUL_W'(t_r);
        mul_b = MUL_W'(t_r);
      end
      OP_COS_X: begin
        mul_a = MUL_W'(t_r);
        mul_b = MUL_W'(HALF_PI_Q30);
      end
      OP_COS_Y: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(x_r);
      end
      OP_COS_RCP: begin
        mul_a = y_r;
        mul_b = MUL_W'(cos_recip(cmd.step));
      end
      OP_COS_MUL: begin
        mul_a = MUL_W'(q_r);
        mul_b = MUL_W'(p_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    ddx     = (CRD_W+1)'(in_data.vertex_x) - (CRD_W+1)'(cx_r);
    ddy     = (CRD_W+1)'(in_data.vertex_y) - (CRD_W+1)'(cy_r);
    adx_nxt = ddx[CRD_W] ? ROOT_W'(-ddx) : ROOT_W'(ddx);
    ady_nxt = ddy[CRD_W] ? ROOT_W'(-ddy) : ROOT_W'(ddy);
    rem_sh  = {srem_r, acc_r[SQ_W-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    num     = (mode_r == MODE_COSINE) ? root_r[RAD_W-1:0]
                                      : rad_r - root_r[RAD_W-1:0];
    qk      = 37'(qa_r) * 37'(kdiv);
    crem    = 37'(y_r) - qk;
    prod30  = mul_p[61:30];
    wsum    = {1'b0, p_r} + 32'd8192;
    sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    q24     = div_q[CRD_W-1:0];
  end

  always_comb begin
    rr_nxt      = rr_r;
    acc_nxt     = acc_r;
    aff_nxt     = aff_r;
    srem_nxt    = srem_r;
    root_nxt    = root_r;
    w_nxt       = w_r;
    t_nxt       = t_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    qa_nxt      = qa_r;
    q_nxt       = q_r;
    p_nxt       = p_r;
    sum_nxt     = sum_r;
    count_nxt   = count_r;
    avg_nxt     = avg_r;
    avalid_nxt  = avalid_r;
    out_nxt     = out_r;
    div_start   = 1'b0;
    div_a       = '0;
    div_b       = '0;
    case (cmd.op)
      OP_LOAD: begin
        avg_nxt    = '0;
        avalid_nxt = 1'b0;
      end
      OP_SQ_R: rr_nxt  = mul_p[45:0];
      OP_SQ_X: acc_nxt = mul_p[SQ_W-1:0];
      OP_SQ_Y: acc_nxt = acc_r + mul_p[SQ_W-1:0];
      OP_CMP: begin
        aff_nxt  = acc_r <= SQ_W'(rr_r);
        srem_nxt = '0;
        root_nxt = '0;
      end
      OP_SQRT: begin
        // Two bits of the sum of squares enter the root each cycle.
        acc_nxt = {acc_r[SQ_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          srem_nxt = REM_W'(rem_sh - trial);
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          srem_nxt = rem_sh[REM_W-1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      OP_WSEL: begin
        w_nxt = (aff_r && trivial) ? WGT_ONE : '0;
        if (aff_r && !trivial) begin
          div_start = 1'b1;
          div_a     = DIV_NW'({num, 16'h0000});
          div_b     = DIV_DW'(rad_r);
        end
      end
      OP_TAKE_W: begin
        w_nxt = div_q[WGT_W-1:0];
        t_nxt = div_q[WGT_W-1:0];
      end
      OP_SQUARE: w_nxt = WGT_W'((mul_p[33:0] + 34'd32768) >> 16);
      OP_COS_X:  x_nxt = mul_p[46:16];
      OP_COS_Y: begin
        y_nxt = mul_p[61:30];
        p_nxt = Q30_ONE[30:0];
      end
      OP_COS_RCP: qa_nxt = mul_p[60:32];
      OP_COS_FIX: q_nxt = 31'(qa_r) + ((crem >= 37'(kdiv)) ? 31'd1 : 31'd0);
      OP_COS_HALF: q_nxt = y_r[31:1];
      OP_COS_MUL: p_nxt = (prod30 >= Q30_ONE) ? 31'd0 : 31'(Q30_ONE - prod30);
      OP_COS_END: w_nxt = (wsum[31:14] > 18'(WGT_ONE)) ? WGT_ONE : wsum[30:14];
      OP_ACCUM: begin
        if (aff_r && !count_full) begin
          sum_nxt   = sum_r + SUM_W'(hgt_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_AVG_START: begin
        div_start = 1'b1;
        div_a     = DIV_NW'(sum_mag);
        div_b     = DIV_DW'(count_r);
      end
      OP_TAKE_A: begin
        avg_nxt    = sum_r[SUM_W-1] ? CRD_W'(-q24) : q24;
        avalid_nxt = 1'b1;
      end
      OP_OUT: begin
        out_nxt.out_index      = idx_r;
        out_nxt.affected       = aff_r;
        out_nxt.distance       = root_r[ROOT_W-1] ? '1 : root_r[DIST_W-1:0];
        out_nxt.weight         = w_r;
        out_nxt.out_last       = last_r;
        out_nxt.average_height = avg_r;
        out_nxt.average_valid  = avalid_r;
        if (last_r) begin
          sum_nxt   = '0;
          count_nxt = '0;
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  rbf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      adx_r  <= adx_nxt;
      ady_r  <= ady_nxt;
      hgt_r  <= in_data.vertex_height;
      idx_r  <= in_data.vertex_index;
      last_r <= in_data.batch_last;
    end
    rr_r     <= rr_nxt;
    acc_r    <= acc_nxt;
    aff_r    <= aff_nxt;
    srem_r   <= srem_nxt;
    root_r   <= root_nxt;
    w_r      <= w_nxt;
    t_r      <= t_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    qa_r     <= qa_nxt;
    q_r      <= q_nxt;
    p_r      <= p_nxt;
    avg_r    <= avg_nxt;
    avalid_r <= avalid_nxt;
    out_r    <= out_nxt;
    if (!rst_n) begin
      cx_r    <= '0;
      cy_r    <= '0;
      rad_r   <= 23'd1024;
      mode_r  <= MODE_COSINE;
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER_X: cx_r   <= cfg_data;
          CFG_CENTER_Y: cy_r   <= cfg_data;
          CFG_RADIUS:   rad_r  <= cfg_data[RAD_W-1:0];
          CFG_MODE:     mode_r <= cfg_data[1:0];
          default:      mode_r <= mode_r;
        endcase
      end
    end
  end

  always_comb begin
    sts.aff      = aff_r;
    sts.trivial  = trivial;
    sts.mode     = mode_r;
    sts.last     = last_r;
    sts.count_nz = count_r != '0;
    sts.div_done = div_done;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== hdl/rbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbf_ctrl: controller of the radial brush falloff weight block
// Sequences one vertex through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_ctrl
  import rbf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       ov_r, ov_nxt;
  logic       out_free;

  assign out_free = !ov_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_SQ_R;
      S_SQ_R:     state_nxt = S_SQ_X;
      S_SQ_X:     state_nxt = S_SQ_Y;
      S_SQ_Y:     state_nxt = S_CMP;
      S_CMP: begin
        state_nxt = S_SQRT;
        cnt_nxt   = '0;
      end
      S_SQRT: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(SQRT_STEPS - 1)) state_nxt = S_WSEL;
      end
      S_WSEL:     state_nxt = (sts.aff && !sts.trivial) ? S_DIV_W : S_ACCUM;
      S_DIV_W: begin
        if (sts.div_done) begin
          case (sts.mode)
            MODE_SQUARE: state_nxt = S_SQUARE;
            MODE_COSINE: state_nxt = S_COS_X;
            default:     state_nxt = S_ACCUM;
          endcase
        end
      end
      S_SQUARE:   state_nxt = S_ACCUM;
      S_COS_X:    state_nxt = S_COS_Y;
      S_COS_Y: begin
        state_nxt = S_COS_RCP;
        cnt_nxt   = '0;
      end
      S_COS_RCP:  state_nxt = S_COS_FIX;
      S_COS_FIX:  state_nxt = S_COS_MUL;
      S_COS_MUL: begin
        if (cnt_r == 6'(COS_STEPS - 1)) begin
          state_nxt = S_COS_HALF;
        end else begin
          state_nxt = S_COS_RCP;
          cnt_nxt   = cnt_r + 6'd1;
        end
      end
      S_COS_HALF: state_nxt = S_COS_FMUL;
      S_COS_FMUL: state_nxt = S_COS_END;
      S_COS_END:  state_nxt = S_ACCUM;
      S_ACCUM:    state_nxt = S_AVG_CHK;
      S_AVG_CHK:  state_nxt = (sts.last && sts.count_nz) ? S_DIV_A : S_OUT;
      S_DIV_A:    if (sts.div_done) state_nxt = S_OUT;
      S_OUT:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.step = cnt_r[2:0];
    case (state_r)
      S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_SQ_R:     cmd.op = OP_SQ_R;
      S_SQ_X:     cmd.op = OP_SQ_X;
      S_SQ_Y:     cmd.op = OP_SQ_Y;
      S_CMP:      cmd.op = OP_CMP;
      S_SQRT:     cmd.op = OP_SQRT;
      S_WSEL:     cmd.op = OP_WSEL;
      S_DIV_W:    cmd.op = sts.div_done ? OP_TAKE_W : OP_NONE;
      S_SQUARE:   cmd.op = OP_SQUARE;
      S_COS_X:    cmd.op = OP_COS_X;
      S_COS_Y:    cmd.op = OP_COS_Y;
      S_COS_RCP:  cmd.op = OP_COS_RCP;
      S_COS_FIX:  cmd.op = OP_COS_FIX;
      S_COS_MUL:  cmd.op = OP_COS_MUL;
      S_COS_HALF: cmd.op = OP_COS_HALF;
      S_COS_FMUL: cmd.op = OP_COS_MUL;
      S_COS_END:  cmd.op = OP_COS_END;
      S_ACCUM:    cmd.op = OP_ACCUM;
      S_AVG_CHK:  cmd.op = (sts.last && sts.count_nz) ? OP_AVG_START : OP_NONE;
      S_DIV_A:    cmd.op = sts.div_done ? OP_TAKE_A : OP_NONE;
      S_OUT:      cmd.op = out_free ? OP_OUT : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

  // The result register stays full until its transfer completes.
  always_comb begin
    ov_nxt = ov_r && out_stall;
    if (state_r == S_OUT && out_free) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = ov_r;

endmodule

`default_nettype wire

// ===== hdl/radial_brush_falloff_weight.sv =====
// ----------------------------------------------------------------------------
// radial_brush_falloff_weight: brush weight and batch mean height per vertex
// Distance to the brush centre, falloff weight and running height average.
// ----------------------------------------------------------------------------
// One vertex is in work at a time. A vertex that needs no weight division
// (outside the brush, constant mode or zero radius) passes the squares, the
// bit-serial square root, the batch sum and the output register. Linear mode
// adds a weight division in the shared radix-2 divider, squared mode that
// division and a squaring step, cosine mode that division and the cosine
// series; the last vertex of a non-empty batch adds the average division.
// A new vertex is taken while the previous result waits in the output register.
`default_nettype none

module radial_brush_falloff_weight
  import rbf_pkg::*;
#(
  parameter int MAX_VERTICES = 1048576
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rbf_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== hdl/rbf_chk.sv =====
// ----------------------------------------------------------------------------
// rbf_chk: port checker for the radial brush falloff weight block
// Concurrent assertions on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_chk
  import rbf_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall || !rst_n)
    else $error("second vertex taken while one is in work");

  a_avg_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_last |-> !out_data.average_valid)
    else $error("average reported on a result that is not last");

  a_weight_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.affected |-> out_data.weight == '0)
    else $error("nonzero weight on an unaffected vertex");

endmodule

bind radial_brush_falloff_weight rbf_chk u_rbf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
